// ----- hw/rtl/array_factor_accumulator_macros.svh -----
// Assertion macros for the array factor accumulator.
// Used by the top level only; no other dependencies.
`ifndef ARRAY_FACTOR_ACCUMULATOR_MACROS_SVH
`define ARRAY_FACTOR_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define AFA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("array factor accumulator assertion failed");

// Next-cycle implication, disabled while in reset.
`define AFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("array factor accumulator assertion failed");

`endif

// ----- hw/rtl/afa_pkg.sv -----
// Shared types, constants and the CORDIC angle table of the array factor accumulator.
// No dependencies.
package afa_pkg;

  localparam int unsigned DIR_W    = 32;
  localparam int unsigned AF_W     = 32;
  localparam int unsigned SUM_W    = 40;
  localparam int unsigned USED_W   = 8;
  localparam int unsigned CORDIC_W = 34;
  localparam int unsigned DOT_W    = 52;

  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [CORDIC_W-1:0] ONE_Q30   = 34'sd1073741824;

  typedef enum logic [1:0] {
    REG_PHASE_SCALE,
    REG_REF_DIR_X,
    REG_REF_DIR_Y,
    REG_REF_DIR_Z
  } cfg_reg_e;

  typedef enum logic [2:0] {
    MS_X,
    MS_Y,
    MS_Z,
    MS_LO,
    MS_HI
  } mul_sel_e;

  typedef enum logic [1:0] {
    DOT_HOLD,
    DOT_LOAD,
    DOT_ADD
  } dot_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MX,
    ST_MY,
    ST_MZ,
    ST_MW,
    ST_PL,
    ST_PH,
    ST_PF,
    ST_CI,
    ST_CR,
    ST_ACC,
    ST_DL,
    ST_DV,
    ST_DO
  } afa_state_e;

  typedef struct packed {
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic signed [DIR_W-1:0] off_x;
    logic signed [DIR_W-1:0] off_y;
    logic signed [DIR_W-1:0] off_z;
    logic                    flag_x;
    logic                    flag_y;
    logic                    last_element;
  } in_item_t;

  typedef struct packed {
    logic signed [AF_W-1:0] afx_re;
    logic signed [AF_W-1:0] afx_im;
    logic signed [AF_W-1:0] afy_re;
    logic signed [AF_W-1:0] afy_im;
    logic [USED_W-1:0]      used_x;
    logic [USED_W-1:0]      used_y;
  } out_item_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_e mul_sel;
    dot_op_e  dot_op;
    logic     ph_lo;
    logic     ph_fin;
    logic     cor_init;
    logic     cor_step;
    logic     acc;
    logic     div_start;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic last;
    logic cor_done;
    logic div_done;
    logic out_free;
  } status_t;

  // atan(2^-i) in 2^-32 turns, rounded to nearest
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10680862;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      5'd31: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/afa_in_if.sv -----
// Input element channel: valid/ready handshake with the element payload.
// Depends on afa_pkg.
interface afa_in_if;
  logic             valid;
  logic             ready;
  afa_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/afa_out_if.sv -----
// Result channel: valid/ready handshake with the normalised array factors.
// Depends on afa_pkg.
interface afa_out_if;
  logic               valid;
  logic               ready;
  afa_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/afa_div.sv -----
// Four-lane restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on afa_pkg.
module afa_div #(
  parameter int unsigned CNT_W = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [afa_pkg::SUM_W-1:0] num_i [4],
  input  logic        [CNT_W-1:0]          den_x_i,
  input  logic        [CNT_W-1:0]          den_y_i,
  output logic signed [afa_pkg::AF_W-1:0]  quo_o [4],
  output logic                             done_o
);
  import afa_pkg::*;

  localparam int unsigned CW = $clog2(SUM_W);

  logic          busy_q;
  logic [CW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(SUM_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign done_o = !busy_q;

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [SUM_W-1:0] mag_q;
    logic [CNT_W-1:0] rem_q;
    logic [CNT_W-1:0] den_q;
    logic             neg_q;
    logic             zero_q;
    logic [CNT_W:0]   trial;
    logic             fits;
    logic [SUM_W-1:0] res;

    assign trial = {rem_q, mag_q[SUM_W-1]};
    assign fits  = trial >= {1'b0, den_q};

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        mag_q  <= num_i[l][SUM_W-1] ? SUM_W'(-num_i[l]) : SUM_W'(num_i[l]);
        neg_q  <= num_i[l][SUM_W-1];
        rem_q  <= '0;
        den_q  <= (l < 2) ? den_x_i : den_y_i;
        zero_q <= ((l < 2) ? den_x_i : den_y_i) == '0;
      end else if (busy_q) begin
        rem_q <= fits ? CNT_W'(trial - {1'b0, den_q}) : CNT_W'(trial);
        mag_q <= {mag_q[SUM_W-2:0], fits};
      end
    end

    assign res      = neg_q ? SUM_W'(-mag_q) : mag_q;
    assign quo_o[l] = zero_q ? '0 : AF_W'(res);
  end

endmodule

// ----- hw/rtl/afa_datapath.sv -----
// Datapath: config registers, shared multiplier, phase, CORDIC, sums and result register.
// Depends on afa_pkg and afa_div.
module afa_datapath #(
  parameter int unsigned MAX_ELEMENTS = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  afa_pkg::in_item_t  in_data_i,
  input  afa_pkg::cmd_t      cmd_i,
  output afa_pkg::status_t   status_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output afa_pkg::out_item_t out_data_o
);
  import afa_pkg::*;

  localparam int unsigned TW = $clog2(MAX_ELEMENTS + 1);

  logic        [31:0]         ps_q;
  logic signed [31:0]         ref_x_q, ref_y_q, ref_z_q;
  in_item_t                   item_q;
  logic signed [66:0]         prod_q;
  logic signed [DOT_W-1:0]    dot_q;
  logic        [31:0]         phlo_q, phase_q;
  logic        [1:0]          quad_q;
  logic signed [CORDIC_W-1:0] x_q, y_q, z_q;
  logic        [4:0]          iter_q;
  logic signed [SUM_W-1:0]    sxr_q, sxi_q, syr_q, syi_q;
  logic        [TW-1:0]       tx_q, ty_q;
  logic                       out_valid_q;
  out_item_t                  out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q    <= '0;
      ref_x_q <= '0;
      ref_y_q <= '0;
      ref_z_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PHASE_SCALE: ps_q    <= cfg_data_i;
        REG_REF_DIR_X:   ref_x_q <= cfg_data_i;
        REG_REF_DIR_Y:   ref_y_q <= cfg_data_i;
        REG_REF_DIR_Z:   ref_z_q <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      item_q <= in_data_i;
    end
  end

  // shared multiplier: geometry terms, then the phase in two halves
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [66:0] mul_res;
  logic signed [61:0] dot_ext;

  assign dot_ext = 62'(dot_q);

  always_comb begin
    unique case (cmd_i.mul_sel)
      MS_X: begin
        mul_a = 34'(item_q.dir_x) - 34'(ref_x_q);
        mul_b = 33'(item_q.off_x);
      end
      MS_Y: begin
        mul_a = 34'(item_q.dir_y) - 34'(ref_y_q);
        mul_b = 33'(item_q.off_y);
      end
      MS_Z: begin
        mul_a = 34'(item_q.dir_z) - 34'(ref_z_q);
        mul_b = 33'(item_q.off_z);
      end
      MS_LO: begin
        mul_a = {2'b00, dot_ext[31:0]};
        mul_b = {1'b0, ps_q};
      end
      MS_HI: begin
        mul_a = {4'b0000, dot_ext[61:32]};
        mul_b = {1'b0, ps_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_res = mul_a * mul_b;

  logic signed [DOT_W-1:0] term;
  assign term = DOT_W'($signed(prod_q[66:16]));

  logic [31:0] quad_sum, z_init;
  logic [1:0]  quad_c;
  assign quad_sum = phase_q + 32'h2000_0000;
  assign quad_c   = quad_sum[31:30];
  assign z_init   = phase_q - {quad_c, 30'd0};

  logic signed [CORDIC_W-1:0] dx, dy, atan_v;
  assign dx     = y_q >>> iter_q;
  assign dy     = x_q >>> iter_q;
  assign atan_v = CORDIC_W'(atan_turn(iter_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= mul_res;
    end
    unique case (cmd_i.dot_op)
      DOT_LOAD: dot_q <= term;
      DOT_ADD:  dot_q <= dot_q + term;
      default:  dot_q <= dot_q;
    endcase
    if (cmd_i.ph_lo) begin
      phlo_q <= prod_q[61:30];
    end
    if (cmd_i.ph_fin) begin
      phase_q <= phlo_q + {prod_q[29:0], 2'b00};
    end
    if (cmd_i.cor_init) begin
      quad_q <= quad_c;
      z_q    <= CORDIC_W'($signed(z_init));
      x_q    <= CORDIC_X0;
      y_q    <= '0;
      iter_q <= '0;
    end else if (cmd_i.cor_step) begin
      iter_q <= iter_q + 1'b1;
      if (!z_q[CORDIC_W-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atan_v;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atan_v;
      end
    end
  end

  // fold the quadrant back in, then clamp to plus or minus one
  logic signed [CORDIC_W-1:0] c_raw, s_raw, c_cl, s_cl;
  always_comb begin
    unique case (quad_q)
      2'd0: begin c_raw = x_q;  s_raw = y_q;  end
      2'd1: begin c_raw = -y_q; s_raw = x_q;  end
      2'd2: begin c_raw = -x_q; s_raw = -y_q; end
      2'd3: begin c_raw = y_q;  s_raw = -x_q; end
    endcase
    c_cl = (c_raw > ONE_Q30) ? ONE_Q30 : ((c_raw < -ONE_Q30) ? -ONE_Q30 : c_raw);
    s_cl = (s_raw > ONE_Q30) ? ONE_Q30 : ((s_raw < -ONE_Q30) ? -ONE_Q30 : s_raw);
  end

  logic add_x, add_y;
  assign add_x = !item_q.flag_x && (tx_q < TW'(MAX_ELEMENTS));
  assign add_y = !item_q.flag_y && (ty_q < TW'(MAX_ELEMENTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sxr_q <= '0;
      sxi_q <= '0;
      syr_q <= '0;
      syi_q <= '0;
      tx_q  <= '0;
      ty_q  <= '0;
    end else if (cmd_i.out_load) begin
      sxr_q <= '0;
      sxi_q <= '0;
      syr_q <= '0;
      syi_q <= '0;
      tx_q  <= '0;
      ty_q  <= '0;
    end else if (cmd_i.acc) begin
      if (add_x) begin
        sxr_q <= sxr_q + SUM_W'(c_cl);
        sxi_q <= sxi_q + SUM_W'(s_cl);
        tx_q  <= tx_q + 1'b1;
      end
      if (add_y) begin
        syr_q <= syr_q + SUM_W'(c_cl);
        syi_q <= syi_q + SUM_W'(s_cl);
        ty_q  <= ty_q + 1'b1;
      end
    end
  end

  logic signed [SUM_W-1:0] div_num [4];
  logic signed [AF_W-1:0]  div_quo [4];
  logic                    div_done;

  assign div_num[0] = sxr_q;
  assign div_num[1] = sxi_q;
  assign div_num[2] = syr_q;
  assign div_num[3] = syi_q;

  afa_div #(
    .CNT_W (TW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_x_i (tx_q),
    .den_y_i (ty_q),
    .quo_o   (div_quo),
    .done_o  (div_done)
  );

  // result register parts the output side from the working side
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.afx_re <= div_quo[0];
      out_q.afx_im <= div_quo[1];
      out_q.afy_re <= div_quo[2];
      out_q.afy_im <= div_quo[3];
      out_q.used_x <= USED_W'(tx_q);
      out_q.used_y <= USED_W'(ty_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.skip     = item_q.flag_x && item_q.flag_y;
  assign status_o.last     = item_q.last_element;
  assign status_o.cor_done = iter_q == 5'd31;
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

// ----- hw/rtl/afa_ctrl.sv -----
// Controller: sequences multiply, phase, CORDIC, accumulate and divide steps.
// Depends on afa_pkg.
module afa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  afa_pkg::status_t status_i,
  output afa_pkg::cmd_t    cmd_o
);
  import afa_pkg::*;

  afa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.mul_sel = MS_X;
    cmd_o.dot_op  = DOT_HOLD;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = ST_MX;
        end
      end
      ST_MX: begin
        if (status_i.skip) begin
          state_d = ST_ACC;
        end else begin
          cmd_o.mul_en = 1'b1;
          state_d = ST_MY;
        end
      end
      ST_MY: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_Y;
        cmd_o.dot_op  = DOT_LOAD;
        state_d = ST_MZ;
      end
      ST_MZ: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_Z;
        cmd_o.dot_op  = DOT_ADD;
        state_d = ST_MW;
      end
      ST_MW: begin
        cmd_o.dot_op = DOT_ADD;
        state_d = ST_PL;
      end
      ST_PL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_LO;
        state_d = ST_PH;
      end
      ST_PH: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_HI;
        cmd_o.ph_lo   = 1'b1;
        state_d = ST_PF;
      end
      ST_PF: begin
        cmd_o.ph_fin = 1'b1;
        state_d = ST_CI;
      end
      ST_CI: begin
        cmd_o.cor_init = 1'b1;
        state_d = ST_CR;
      end
      ST_CR: begin
        cmd_o.cor_step = 1'b1;
        if (status_i.cor_done) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d = status_i.last ? ST_DL : ST_IDLE;
      end
      ST_DL: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DV;
      end
      ST_DV: begin
        if (status_i.div_done) begin
          state_d = ST_DO;
        end
      end
      ST_DO: begin
        // hold until the result register has room
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/array_factor_accumulator.sv -----
// Array factor accumulator: one array element per input beat, one result beat per pixel.
// An element passes from acceptance through 3 geometry multiplies, 2 phase multiplies on
// one shared multiplier, 32 CORDIC iterations and an accumulate; a doubly flagged one goes
// straight to the accumulate. A last element adds the 40-step divider and the result load.
// Reset clears configuration, sums, counts and the result valid flag at once, not the result data.
module array_factor_accumulator #(
  parameter int unsigned MAX_ELEMENTS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  afa_in_if.sink      in_i,
  afa_out_if.source   out_o
);
  import afa_pkg::*;

  `include "array_factor_accumulator_macros.svh"

  cmd_t    cmd;
  status_t status;

  afa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  afa_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

  `AFA_ASSERT_NEXT(a_div_busy, clk_i, rst_ni, cmd.div_start, !status.div_done)
  `AFA_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready)
  `AFA_ASSERT_IMPL(a_out_room, clk_i, rst_ni, cmd.out_load, status.out_free)

endmodule
